>>> design/bit_field_packer_assert.svh
// Assertion macros for the bit field packer.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef BIT_FIELD_PACKER_ASSERT_SVH
`define BIT_FIELD_PACKER_ASSERT_SVH
`ifndef SYNTH
`define BFP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bit_field_packer assertion failed");
`define BFP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit_field_packer assertion failed");
`else
`define BFP_ASSERT(label, prop)
`define BFP_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

>>> design/bfp_pkg.sv
package bfp_pkg;

    localparam int BUF_BYTES = 256;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int POS_W     = 9;    // byte position, 0..BUF_BYTES
    localparam int USED_W    = 12;   // bit position count
    localparam int FIELD_W   = 32;
    localparam int FW_W      = 6;
    localparam int WIN_W     = 40;   // five bytes: 32 bits plus a 7 bit offset
    localparam int IDX_W     = 3;

    typedef enum logic [2:0] {
        CMD_RESTART = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_READ    = 3'd2,
        CMD_LOAD    = 3'd3,
        CMD_FETCH   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_PAST_END = 2'd1,
        STS_BAD_MODE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_ACCESS,
        FSM_FINISH
    } fsm_t;

    localparam logic CFG_PACK_MODE = 1'b0;
    localparam logic CFG_SIZE      = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [BUF_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [BUF_AW-1:0] rd_addr;
        logic              clr_en;
        logic [POS_W-1:0]  clr_limit;
    } store_req_t;

    function automatic logic [FIELD_W-1:0] field_mask(input logic [FW_W-1:0] w);
        logic [FIELD_W:0] m;
        m = ({{FIELD_W{1'b0}}, 1'b1} << w) - {{FIELD_W{1'b0}}, 1'b1};
        return m[FIELD_W-1:0];
    endfunction

endpackage

>>> design/bfp_store.sv
module bfp_store
    import bfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output logic [7:0] rd_byte
);

    logic [7:0]           mem [BUF_BYTES];
    logic [BUF_BYTES-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;

    // byte array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // per-entry valid bits: an entry never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < BUF_BYTES; i++)
            begin
                if (req.clr_en && (POS_W'(i) < req.clr_limit))
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_byte = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

>>> design/bit_field_packer.sv
// LSB-first bit field packer / unpacker over a 256 byte buffer.
// One transaction at a time: cmd_stall rises on accept and drops when the result is
// registered; rsp_stall can keep it high longer. A field write/read takes N buffer beats,
// N = bytes touched (1..5), a fetch one; restart, load, zero-width and refused ones none.
// Async reset: positions zero, pack mode, size 256, buffer reads as zero (valid bits).
`include "bit_field_packer_assert.svh"

module bit_field_packer
    import bfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // config write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_data,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [2:0]          cmd,
    input  logic [FIELD_W-1:0]  field_value,
    input  logic [FW_W-1:0]     field_width,
    input  logic [7:0]          byte_addr,
    input  logic [7:0]          byte_in,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [FIELD_W-1:0]  read_value,
    output logic [7:0]          byte_out,
    output logic [USED_W-1:0]   bits_used,
    output logic [POS_W-1:0]    bytes_used,
    output logic [USED_W-1:0]   bits_left,
    output logic [1:0]          status
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    fsm_t               state_reg, state_next;

    logic               pack_mode_reg;
    logic [POS_W-1:0]   size_reg;

    logic [POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [2:0]         bit_pos_reg, bit_pos_next;

    // transaction context, captured on accept
    logic [2:0]         op_reg, op_next;
    status_t            status_reg, status_next;
    logic [FW_W-1:0]    fw_reg, fw_next;
    logic [2:0]         bit0_reg, bit0_next;
    logic [IDX_W-1:0]   nbytes_reg, nbytes_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BUF_AW-1:0]  base_reg, base_next;
    // pack: shifted field to merge; unpack: gathered bytes
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [7:0]         byte_out_reg, byte_out_next;

    // response register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [FIELD_W-1:0] rsp_value_reg, rsp_value_next;
    logic [7:0]         rsp_byte_reg, rsp_byte_next;
    logic [USED_W-1:0]  rsp_bits_used_reg, rsp_bits_used_next;
    logic [POS_W-1:0]   rsp_bytes_used_reg, rsp_bytes_used_next;
    logic [USED_W-1:0]  rsp_bits_left_reg, rsp_bits_left_next;
    logic [1:0]         rsp_status_reg, rsp_status_next;

    store_req_t         store_req;
    logic [7:0]         rd_byte;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic               cmd_accept;
    logic               rsp_free;
    logic               last_beat;
    logic [POS_W-1:0]   eff_size;
    logic [USED_W-1:0]  total_bits;
    logic [USED_W-1:0]  used_bits;
    logic [FW_W-1:0]    fw_c;
    logic [USED_W-1:0]  field_end;
    logic [6:0]         span_c;
    logic [IDX_W-1:0]   nbytes_c;
    status_t            status_c;
    logic               go_access;
    logic [WIN_W-1:0]   win_shifted;

    assign cmd_stall  = (state_reg != FSM_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign last_beat  = (idx_reg == (nbytes_reg - IDX_W'(1)));

    assign eff_size   = (size_reg > POS_W'(BUF_BYTES)) ? POS_W'(BUF_BYTES) : size_reg;
    assign total_bits = {eff_size, 3'b000};
    assign used_bits  = {byte_pos_reg, bit_pos_reg};
    // widths above 32 act as 32
    assign fw_c       = (field_width > FW_W'(FIELD_W)) ? FW_W'(FIELD_W) : field_width;
    assign field_end  = used_bits + USED_W'(fw_c);
    // bytes touched: ceil((bit offset + width) / 8)
    assign span_c     = 7'(bit_pos_reg) + 7'(fw_c) + 7'd7;
    assign nbytes_c   = span_c[5:3];

    // status of the incoming command and whether it needs buffer beats
    always_comb
    begin
        status_c  = STS_OK;
        go_access = 1'b0;
        case (cmd)
            CMD_RESTART:
            begin
                status_c = STS_OK;
            end
            CMD_WRITE, CMD_READ:
            begin
                if ((cmd == CMD_WRITE) != (pack_mode_reg == 1'b0))
                begin
                    status_c = STS_BAD_MODE;
                end
                else if (field_end > total_bits)
                begin
                    status_c = STS_PAST_END;
                end
                else
                begin
                    go_access = (fw_c != '0);
                end
            end
            CMD_LOAD:
            begin
                if ({1'b0, byte_addr} >= eff_size)
                begin
                    status_c = STS_PAST_END;
                end
            end
            CMD_FETCH:
            begin
                if ({1'b0, byte_addr} >= eff_size)
                begin
                    status_c = STS_PAST_END;
                end
                else
                begin
                    go_access = 1'b1;
                end
            end
            default:
            begin
                status_c = STS_BAD_MODE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = go_access ? FSM_ACCESS : FSM_FINISH;
                end
            end
            FSM_ACCESS:
            begin
                if (last_beat)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and buffer requests
    // ------------------------------------------------------------------
    assign win_shifted = win_reg >> bit0_reg;

    always_comb
    begin
        byte_pos_next       = byte_pos_reg;
        bit_pos_next        = bit_pos_reg;
        op_next             = op_reg;
        status_next         = status_reg;
        fw_next             = fw_reg;
        bit0_next           = bit0_reg;
        nbytes_next         = nbytes_reg;
        idx_next            = idx_reg;
        base_next           = base_reg;
        win_next            = win_reg;
        byte_out_next       = byte_out_reg;
        store_req           = '0;

        rsp_valid_next      = rsp_valid_reg;
        rsp_value_next      = rsp_value_reg;
        rsp_byte_next       = rsp_byte_reg;
        rsp_bits_used_next  = rsp_bits_used_reg;
        rsp_bytes_used_next = rsp_bytes_used_reg;
        rsp_bits_left_next  = rsp_bits_left_reg;
        rsp_status_next     = rsp_status_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE:
            begin
                if (cmd_accept)
                begin
                    op_next       = cmd;
                    status_next   = status_c;
                    fw_next       = fw_c;
                    bit0_next     = bit_pos_reg;
                    // fetch touches exactly one byte, whatever the width field holds
                    nbytes_next   = (cmd == CMD_FETCH) ? IDX_W'(1) : nbytes_c;
                    idx_next      = '0;
                    byte_out_next = 8'd0;
                    base_next     = (cmd == CMD_FETCH) ? byte_addr
                                                       : byte_pos_reg[BUF_AW-1:0];
                    win_next      = (cmd == CMD_WRITE)
                                  ? ({{(WIN_W-FIELD_W){1'b0}},
                                      field_value & field_mask(fw_c)} << bit_pos_reg)
                                  : '0;

                    if (cmd == CMD_RESTART)
                    begin
                        byte_pos_next       = '0;
                        bit_pos_next        = '0;
                        store_req.clr_en    = (pack_mode_reg == 1'b0);
                        store_req.clr_limit = eff_size;
                    end

                    if (cmd == CMD_LOAD && status_c == STS_OK)
                    begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = byte_addr;
                        store_req.wr_data = byte_in;
                    end

                    // first byte read goes out with the accept
                    if (go_access)
                    begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = (cmd == CMD_FETCH) ? byte_addr
                                                               : byte_pos_reg[BUF_AW-1:0];
                    end
                end
            end

            FSM_ACCESS:
            begin
                // byte idx arrives now; byte idx+1 is requested in the same cycle
                case (op_reg)
                    CMD_WRITE:
                    begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = base_reg + BUF_AW'(idx_reg);
                        store_req.wr_data = rd_byte | win_reg[{idx_reg, 3'b000} +: 8];
                    end
                    CMD_READ:
                    begin
                        win_next[{idx_reg, 3'b000} +: 8] = rd_byte;
                    end
                    CMD_FETCH:
                    begin
                        byte_out_next = rd_byte;
                    end
                    default:
                    begin
                        byte_out_next = byte_out_reg;
                    end
                endcase

                if (last_beat)
                begin
                    if (op_reg == CMD_WRITE || op_reg == CMD_READ)
                    begin
                        {byte_pos_next, bit_pos_next} = used_bits + USED_W'(fw_reg);
                    end
                end
                else
                begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = base_reg + BUF_AW'(idx_reg) + BUF_AW'(1);
                    idx_next          = idx_reg + IDX_W'(1);
                end
            end

            FSM_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_value_next      = (op_reg == CMD_READ)
                                        ? (win_shifted[FIELD_W-1:0] & field_mask(fw_reg))
                                        : '0;
                    rsp_byte_next       = byte_out_reg;
                    rsp_bits_used_next  = used_bits;
                    rsp_bytes_used_next = byte_pos_reg + POS_W'(bit_pos_reg != 3'd0);
                    rsp_bits_left_next  = (total_bits > used_bits)
                                        ? (total_bits - used_bits) : '0;
                    rsp_status_next     = status_reg;
                end
            end

            default:
            begin
                store_req = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            byte_pos_reg  <= '0;
            bit_pos_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_pos_reg  <= byte_pos_next;
            bit_pos_reg   <= bit_pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_mode_reg <= 1'b0;
            size_reg      <= POS_W'(BUF_BYTES);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACK_MODE:
                begin
                    pack_mode_reg <= cfg_data[0];
                end
                CFG_SIZE:
                begin
                    size_reg <= cfg_data;
                end
                default:
                begin
                    size_reg <= size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg             <= op_next;
        status_reg         <= status_next;
        fw_reg             <= fw_next;
        bit0_reg           <= bit0_next;
        nbytes_reg         <= nbytes_next;
        idx_reg            <= idx_next;
        base_reg           <= base_next;
        win_reg            <= win_next;
        byte_out_reg       <= byte_out_next;
        rsp_value_reg      <= rsp_value_next;
        rsp_byte_reg       <= rsp_byte_next;
        rsp_bits_used_reg  <= rsp_bits_used_next;
        rsp_bytes_used_reg <= rsp_bytes_used_next;
        rsp_bits_left_reg  <= rsp_bits_left_next;
        rsp_status_reg     <= rsp_status_next;
    end

    // ------------------------------------------------------------------
    // Buffer
    // ------------------------------------------------------------------
    bfp_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_byte (rd_byte)
    );

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = rsp_value_reg;
    assign byte_out   = rsp_byte_reg;
    assign bits_used  = rsp_bits_used_reg;
    assign bytes_used = rsp_bytes_used_reg;
    assign bits_left  = rsp_bits_left_reg;
    assign status     = rsp_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BFP_ASSERT_IMPLY(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg == FSM_FINISH))
    `BFP_ASSERT_IMPLY(a_idx_in_span, state_reg == FSM_ACCESS, idx_reg < nbytes_reg)
    `BFP_ASSERT(a_pos_in_buffer, used_bits <= USED_W'(BUF_BYTES * 8))
    `BFP_ASSERT_IMPLY(a_write_when_busy, store_req.wr_en, state_reg != FSM_FINISH)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfp_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 10;
    // Longest transaction is a 32-bit field over five bytes.
    // Wait longer than that before touching the config port.
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_HALF  = 50;

    localparam logic MODE_PACK   = 1'b0;
    localparam logic MODE_UNPACK = 1'b1;

    // Codes 5..7 are not commands; the block must refuse them.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic [FIELD_W-1:0] value;
        logic [FW_W-1:0]    width;
        logic [7:0]         addr;
        logic [7:0]         data;
    } packer_cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] read_value;
        logic [7:0]         byte_out;
        logic [USED_W-1:0]  bits_used;
        logic [POS_W-1:0]   bytes_used;
        logic [USED_W-1:0]  bits_left;
        logic [1:0]         status;
    } packer_rsp_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic               cfg_index   = 1'b0;
    logic [8:0]         cfg_data    = '0;
    logic               cmd_valid   = 1'b0;
    logic               cmd_stall;
    logic [2:0]         cmd         = '0;
    logic [FIELD_W-1:0] field_value = '0;
    logic [FW_W-1:0]    field_width = '0;
    logic [7:0]         byte_addr   = '0;
    logic [7:0]         byte_in     = '0;
    logic               rsp_valid;
    logic               rsp_stall   = 1'b0;
    logic [FIELD_W-1:0] read_value;
    logic [7:0]         byte_out;
    logic [USED_W-1:0]  bits_used;
    logic [POS_W-1:0]   bytes_used;
    logic [USED_W-1:0]  bits_left;
    logic [1:0]         status;

    // ------------------------------------------------------------------
    // Shadow state of the packer: buffer, bit cursor, registers
    // ------------------------------------------------------------------
    logic [7:0]   shadow_mem [BUF_BYTES];
    int unsigned  bit_cursor = 0;        // byte position * 8 + bit position
    logic         cfg_unpack = MODE_PACK;
    logic [8:0]   cfg_size   = 9'd256;

    packer_cmd_t  cmd_backlog [$];       // transactions waiting for the driver
    packer_rsp_t  rsp_due [$];           // predicted responses, oldest first
    logic         cmd_fire = 1'b0;       // command taken at the last rising edge
    int unsigned  send_gap_pct = 0;
    int unsigned  stall_pct    = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles   = 0;

    int unsigned  phase_sizes [PHASES] = '{256, 12, 3, 0, 40, 1, 300, 8,
                                           256, 2, 511, 16, 5, 64, 256, 20};

    always #CLK_HALF clk = ~clk;

    bit_field_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .field_value (field_value),
        .field_width (field_width),
        .byte_addr   (byte_addr),
        .byte_in     (byte_in),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .read_value  (read_value),
        .byte_out    (byte_out),
        .bits_used   (bits_used),
        .bytes_used  (bytes_used),
        .bits_left   (bits_left),
        .status      (status)
    );

    // Sizes above the buffer clamp to the buffer.
    function automatic int unsigned eff_bytes();
        return (cfg_size < BUF_BYTES) ? cfg_size : BUF_BYTES;
    endfunction

    // Bit-serial model of one transaction. Fields go LSB first starting at the
    // cursor; a byte is full after its bit 7. Packing ORs into the buffer.
    function automatic packer_rsp_t pack_unpack_step(input packer_cmd_t c);
        packer_rsp_t r;
        int unsigned eff;
        int unsigned fw;
        int unsigned at;
        int unsigned total;
        r     = '0;
        eff   = eff_bytes();
        total = eff * 8;
        fw    = (c.width > FIELD_W) ? FIELD_W : c.width;   // wide widths act as 32
        case (c.op)
            CMD_RESTART:
            begin
                bit_cursor = 0;
                if (cfg_unpack == MODE_PACK)
                begin
                    for (int i = 0; i < eff; i++)
                        shadow_mem[i] = 8'h00;
                end
            end
            CMD_WRITE, CMD_READ:
            begin
                // write only in pack mode, read only in unpack mode
                if ((c.op == CMD_WRITE) == (cfg_unpack == MODE_UNPACK))
                    r.status = STS_BAD_MODE;
                else if (bit_cursor + fw > total)
                    r.status = STS_PAST_END;   // also when size dropped below cursor
                else
                begin
                    for (int i = 0; i < fw; i++)
                    begin
                        at = bit_cursor + i;
                        if (c.op == CMD_WRITE)
                            shadow_mem[at / 8][at % 8] = shadow_mem[at / 8][at % 8] | c.value[i];
                        else
                            r.read_value[i] = shadow_mem[at / 8][at % 8];
                    end
                    bit_cursor = bit_cursor + fw;
                end
            end
            CMD_LOAD:
            begin
                if (c.addr >= eff)
                    r.status = STS_PAST_END;
                else
                    shadow_mem[c.addr] = c.data;
            end
            CMD_FETCH:
            begin
                if (c.addr >= eff)
                    r.status = STS_PAST_END;
                else
                    r.byte_out = shadow_mem[c.addr];
            end
            default:
                r.status = STS_BAD_MODE;
        endcase
        r.bits_used  = USED_W'(bit_cursor);
        r.bytes_used = POS_W'((bit_cursor + 7) / 8);
        r.bits_left  = USED_W'((total > bit_cursor) ? total - bit_cursor : 0);
        return r;
    endfunction

    function automatic packer_cmd_t make_cmd(input logic [2:0] op,
                                             input logic [FIELD_W-1:0] value,
                                             input logic [FW_W-1:0] width,
                                             input logic [7:0] addr,
                                             input logic [7:0] data);
        packer_cmd_t c;
        c.op    = op;
        c.value = value;
        c.width = width;
        c.addr  = addr;
        c.data  = data;
        return c;
    endfunction

    // Mostly field transactions that suit the current mode, so the cursor walks
    // deep into the buffer; the rest is restarts, raw byte access and junk.
    function automatic packer_cmd_t random_cmd(input int unsigned eff);
        packer_cmd_t c;
        int unsigned roll;
        c.value = $urandom;
        c.data  = 8'($urandom_range(255));
        c.addr  = 8'($urandom_range(255));
        if (eff != 0 && $urandom_range(3) != 0)
            c.addr = 8'($urandom_range(eff - 1));
        // now and then a zero or oversize width
        if ($urandom_range(19) == 0)
            c.width = FW_W'($urandom_range(63));
        else
            c.width = FW_W'($urandom_range(FIELD_W, 1));
        roll = $urandom_range(99);
        if (roll < 70)
            c.op = (cfg_unpack == MODE_UNPACK) ? CMD_READ : CMD_WRITE;
        else if (roll < 76)
            c.op = CMD_RESTART;
        else if (roll < 84)
            c.op = CMD_LOAD;
        else if (roll < 92)
            c.op = CMD_FETCH;
        else if (roll < 97)
            c.op = (cfg_unpack == MODE_UNPACK) ? CMD_WRITE : CMD_READ;
        else
            c.op = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        return c;
    endfunction

    task automatic flag_mismatch(input string what, input packer_rsp_t want,
                                 input packer_rsp_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t ns: %s", $time, what);
            $display("  read_value exp %h got %h  byte_out exp %h got %h",
                     want.read_value, got.read_value, want.byte_out, got.byte_out);
            $display("  bits_used exp %0d got %0d  bytes_used exp %0d got %0d",
                     want.bits_used, got.bits_used, want.bytes_used, got.bytes_used);
            $display("  bits_left exp %0d got %0d  status exp %0d got %0d",
                     want.bits_left, got.bits_left, want.status, got.status);
        end
    endtask

    // Register writes only happen with the block idle; the shadow copy follows.
    task automatic write_reg(input logic index, input logic [8:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == CFG_PACK_MODE)
            cfg_unpack = value[0];
        else
            cfg_size = value;
    endtask

    // Sender holds off until every transaction is answered, then lets the
    // block settle. Sampled at the rising edge, where none of these move
    // except the response queue, so no ordering race can end it early.
    task automatic drain();
        while (cmd_backlog.size() != 0 || cmd_valid || rsp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: command channel, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        packer_cmd_t nxt;
        // a stalled transaction stays put; otherwise load the next one or go idle
        if (rst_n && (!cmd_valid || cmd_fire))
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                nxt = cmd_backlog.pop_front();
                cmd         <= nxt.op;
                field_value <= nxt.value;
                field_width <= nxt.width;
                byte_addr   <= nxt.addr;
                byte_in     <= nxt.data;
                cmd_valid   <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Response backpressure
    always @(negedge clk)
        rsp_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // Monitor: checks responses, predicts on command acceptance, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        packer_rsp_t got;
        packer_rsp_t want;
        if (rst_n)
        begin
            // retire the oldest prediction before adding a new one
            if (rsp_valid && !rsp_stall)
            begin
                got = {read_value, byte_out, bits_used, bytes_used, bits_left, status};
                if (rsp_due.size() == 0)
                    flag_mismatch("response with no transaction outstanding", '0, got);
                else
                begin
                    want = rsp_due.pop_front();
                    if (got !== want)
                        flag_mismatch("response fields differ", want, got);
                end
            end
            if (cmd_valid && !cmd_stall)
                rsp_due.push_back(pack_unpack_step({cmd, field_value, field_width,
                                                    byte_addr, byte_in}));
            cmd_fire <= cmd_valid && !cmd_stall;

            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned eff;
        foreach (shadow_mem[i])
            shadow_mem[i] = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: pack mode, full buffer. Width extremes, zero and oversize
        // widths, wrong-mode read, unused codes, raw bytes at both ends.
        write_reg(CFG_PACK_MODE, 9'(MODE_PACK));
        write_reg(CFG_SIZE, 9'd256);
        cmd_backlog.push_back(make_cmd(CMD_RESTART, '0, '0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd1, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd32, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'h0000_0000, 6'd7, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hA5A5_A5A5, 6'd63, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'h1234_5678, 6'd33, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_READ, '0, 6'd8, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED_LO, '1, 6'd8, 8'hFF, 8'hFF));
        cmd_backlog.push_back(make_cmd(CMD_UNUSED_HI, '1, 6'd8, 8'hFF, 8'hFF));
        cmd_backlog.push_back(make_cmd(CMD_LOAD, '0, '0, 8'hFF, 8'hFF));
        cmd_backlog.push_back(make_cmd(CMD_FETCH, '0, '0, 8'hFF, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FETCH, '0, '0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_FETCH, '0, '0, 8'h01, 8'h00));
        drain();

        // Shrink the buffer under the cursor: past end with bits_left at zero,
        // then a restart that clears only the two bytes in use.
        write_reg(CFG_SIZE, 9'd2);
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd16, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RESTART, '0, '0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd16, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, 32'hFFFF_FFFF, 6'd1, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_LOAD, '0, '0, 8'h02, 8'h5A));
        cmd_backlog.push_back(make_cmd(CMD_FETCH, '0, '0, 8'hFF, 8'h00));
        drain();

        // Mode switch keeps the cursor; restart in unpack mode keeps the data.
        write_reg(CFG_PACK_MODE, 9'(MODE_UNPACK));
        cmd_backlog.push_back(make_cmd(CMD_READ, '0, 6'd1, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_RESTART, '0, '0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_READ, '0, 6'd16, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_READ, '0, 6'd0, 8'h00, 8'h00));
        cmd_backlog.push_back(make_cmd(CMD_WRITE, '1, 6'd8, 8'h00, 8'h00));
        drain();

        // Random phases: every mode against every idling pattern, a spread of
        // buffer sizes. Each phase drains halfway so the sender waits for
        // the block to empty out at least once per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 59; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 59; end
                default: begin send_gap_pct = 32; stall_pct = 32; end
            endcase
            write_reg(CFG_PACK_MODE, 9'(((p / 4) % 2 == 1) ? MODE_UNPACK : MODE_PACK));
            write_reg(CFG_SIZE, 9'(phase_sizes[p]));
            eff = eff_bytes();
            if ($urandom_range(3) != 0)
                cmd_backlog.push_back(make_cmd(CMD_RESTART, $urandom,
                                               FW_W'($urandom_range(63)),
                                               8'($urandom_range(255)),
                                               8'($urandom_range(255))));
            for (int half = 0; half < 2; half++)
            begin
                for (int n = 0; n < ITEMS_PER_HALF; n++)
                    cmd_backlog.push_back(random_cmd(eff));
                drain();
            end
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> bit_field_packer.f
+incdir+design
design/bfp_pkg.sv
design/bfp_store.sv
design/bit_field_packer.sv
tb/tb.sv
